@@ sv/clkms_pkg.sv @@
// ----------------------------------------------------------------------------
// clkms_pkg
// Shared types, step numbers and the control-store program of the
// multiplier/shift calculator.
// ----------------------------------------------------------------------------
package clkms_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned WideWidth = 64;

   typedef logic [3:0] step_type;

   // Program step numbers.
   localparam step_type STEP_IDLE    = 4'd0;
   localparam step_type STEP_CHKZ    = 4'd1;
   localparam step_type STEP_MUL     = 4'd2;
   localparam step_type STEP_ROOM    = 4'd3;
   localparam step_type STEP_DIVINIT = 4'd4;
   localparam step_type STEP_DIVSTEP = 4'd5;
   localparam step_type STEP_TEST    = 4'd6;
   localparam step_type STEP_DECS    = 4'd7;
   localparam step_type STEP_WAIT    = 4'd8;
   localparam step_type STEP_EMIT    = 4'd9;
   localparam step_type STEP_ERR     = 4'd10;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL,
      OP_ROOM,
      OP_DIVINIT,
      OP_DIVSTEP,
      OP_DECS,
      OP_EMIT,
      OP_ERR
   } op_type;

   typedef enum logic [3:0] {
      C_ALWAYS,
      C_NOT_START,
      C_SRC_ZERO,
      C_UPPER_NZ,
      C_CNT_NZ,
      C_FITS,
      C_S_MORE,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic src_zero;
      logic upper_nz;
      logic cnt_nz;
      logic fits;
      logic s_more;
   } dp_status_type;

   // Control store. When the condition holds the sequencer jumps to the
   // target, otherwise it goes on to the next step.
   function automatic ctrl_word_type ucode(input step_type pc);
      ctrl_word_type w;
      case (pc)
         STEP_IDLE:    w = '{OP_LOAD,    C_NOT_START, STEP_IDLE};
         STEP_CHKZ:    w = '{OP_NOP,     C_SRC_ZERO,  STEP_ERR};
         STEP_MUL:     w = '{OP_MUL,     C_ALWAYS,    STEP_ROOM};
         STEP_ROOM:    w = '{OP_ROOM,    C_UPPER_NZ,  STEP_ROOM};
         STEP_DIVINIT: w = '{OP_DIVINIT, C_ALWAYS,    STEP_DIVSTEP};
         STEP_DIVSTEP: w = '{OP_DIVSTEP, C_CNT_NZ,    STEP_DIVSTEP};
         STEP_TEST:    w = '{OP_NOP,     C_FITS,      STEP_WAIT};
         STEP_DECS:    w = '{OP_DECS,    C_S_MORE,    STEP_DIVINIT};
         STEP_WAIT:    w = '{OP_NOP,     C_OUT_BUSY,  STEP_WAIT};
         STEP_EMIT:    w = '{OP_EMIT,    C_ALWAYS,    STEP_IDLE};
         STEP_ERR:     w = '{OP_ERR,     C_ALWAYS,    STEP_WAIT};
         default:      w = '{OP_NOP,     C_ALWAYS,    STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ sv/clkms_dp.sv @@
// ----------------------------------------------------------------------------
// clkms_dp
// Datapath: span product, headroom count, restoring 64/32 divider and
// shift bookkeeping, driven one operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module clkms_dp
   import clkms_pkg::*;
(
   input  logic                 clock,
   input  op_type               op,
   input  logic [WordWidth-1:0] source_hz,
   input  logic [WordWidth-1:0] target_hz,
   input  logic [WordWidth-1:0] max_seconds,
   output dp_status_type        status,
   output logic [WordWidth-1:0] mult_factor,
   output logic [5:0]           shift_amount,
   output logic                 divide_error
);

   logic [WordWidth-1:0] src_ff, span_ff, upper_ff, rem_ff;
   logic [WideWidth-1:0] num_ff, quo_ff;
   logic [5:0]           room_ff, s_ff, cnt_ff;
   logic                 err_ff;

   logic [WordWidth:0]   trial;
   logic                 trial_ge;
   logic [WideWidth-1:0] product;

   assign trial    = {rem_ff, quo_ff[WideWidth-1]};
   assign trial_ge = trial >= {1'b0, src_ff};
   assign product  = WideWidth'(span_ff) * WideWidth'(src_ff);

   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            src_ff  <= source_hz;
            span_ff <= max_seconds;
            num_ff  <= {target_hz, {WordWidth{1'b0}}};
            room_ff <= 6'd32;
            s_ff    <= 6'd32;
            err_ff  <= 1'b0;
         end
         OP_MUL: begin
            upper_ff <= product[WideWidth-1:WordWidth];
         end
         OP_ROOM: begin
            if (upper_ff != '0) begin
               upper_ff <= upper_ff >> 1;
               room_ff  <= room_ff - 6'd1;
            end
         end
         OP_DIVINIT: begin
            quo_ff <= num_ff + {{(WordWidth + 1){1'b0}}, src_ff[WordWidth-1:1]};
            rem_ff <= '0;
            cnt_ff <= 6'd63;
         end
         OP_DIVSTEP: begin
            if (trial_ge) begin
               rem_ff <= WordWidth'(trial - {1'b0, src_ff});
            end else begin
               rem_ff <= trial[WordWidth-1:0];
            end
            quo_ff <= {quo_ff[WideWidth-2:0], trial_ge};
            cnt_ff <= cnt_ff - 6'd1;
         end
         OP_DECS: begin
            s_ff   <= s_ff - 6'd1;
            num_ff <= num_ff >> 1;
         end
         OP_ERR: begin
            quo_ff <= '0;
            s_ff   <= '0;
            err_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status.src_zero = src_ff == '0;
      status.upper_nz = upper_ff != '0;
      status.cnt_nz   = cnt_ff != '0;
      status.fits     = (quo_ff >> room_ff) == '0;
      status.s_more   = s_ff != 6'd1;
   end

   assign mult_factor  = quo_ff[WordWidth-1:0];
   assign shift_amount = s_ff;
   assign divide_error = err_ff;

endmodule

@@ sv/clock_mult_shift_calc.sv @@
// ----------------------------------------------------------------------------
// clock_mult_shift_calc
// A zero source frequency skips straight to the error step; otherwise the
// sequencer counts headroom, then runs trial shifts, up to 32 of them, each
// built around a full pass of the 64-step restoring divider loop. One
// request is worked at a time; a new one is accepted once the sequencer is
// back at its idle step, even while the previous result waits on rsp_tready.
// Synchronous reset returns the sequencer to idle and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module clock_mult_shift_calc
   import clkms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] source_hz, [63:32] target_hz, [95:64] max_seconds
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] mult_factor, [37:32] shift_amount, [39:38] zero
   output logic [39:0] rsp_tdata,
   // [0] divide_error
   output logic [0:0]  rsp_tuser
);

   // The sequencer walks a small program: check for a zero source, form the
   // span product, count headroom one bit a cycle, then for each shift run a
   // full restoring division and test whether the quotient fits.
   step_type      pc_ff, pc_in;
   ctrl_word_type ctrl;
   op_type        dp_op;
   dp_status_type status;
   logic          req_fire;
   logic          cond_true;

   logic [WordWidth-1:0] mult_factor;
   logic [5:0]           shift_amount;
   logic                 divide_error;

   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [WordWidth-1:0] rsp_mult_ff;
   logic [5:0]           rsp_shift_ff;
   logic                 rsp_err_ff;

   assign ctrl       = ucode(pc_ff);
   assign req_tready = pc_ff == STEP_IDLE;
   assign req_fire   = req_tvalid && req_tready;

   // The load operation only takes effect on an accepted request.
   assign dp_op = (ctrl.op == OP_LOAD && !req_fire) ? OP_NOP : ctrl.op;

   clkms_dp u_dp (
      .clock        (clock),
      .op           (dp_op),
      .source_hz    (req_tdata[31:0]),
      .target_hz    (req_tdata[63:32]),
      .max_seconds  (req_tdata[95:64]),
      .status       (status),
      .mult_factor  (mult_factor),
      .shift_amount (shift_amount),
      .divide_error (divide_error)
   );

   // Branch condition selected by the current control word.
   always_comb begin
      case (ctrl.cond)
         C_ALWAYS:    cond_true = 1'b1;
         C_NOT_START: cond_true = !req_fire;
         C_SRC_ZERO:  cond_true = status.src_zero;
         C_UPPER_NZ:  cond_true = status.upper_nz;
         C_CNT_NZ:    cond_true = status.cnt_nz;
         C_FITS:      cond_true = status.fits;
         C_S_MORE:    cond_true = status.s_more;
         C_OUT_BUSY:  cond_true = rsp_tvalid_ff;
         default:     cond_true = 1'b1;
      endcase
   end

   // Next step: jump on a true condition, otherwise fall through.
   always_comb begin
      pc_in = cond_true ? ctrl.target : pc_ff + step_type'(1);
   end

   // The output register is only loaded after the wait step has seen it
   // empty, so a pending result is never overwritten.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (ctrl.op == OP_EMIT) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_EMIT) begin
         rsp_mult_ff  <= mult_factor;
         rsp_shift_ff <= shift_amount;
         rsp_err_ff   <= divide_error;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_shift_ff, rsp_mult_ff};
   assign rsp_tuser  = rsp_err_ff;

`ifndef ASSERT_OFF
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= STEP_ERR)
      else $error("sequencer left the program");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> rsp_shift_ff <= 6'd32)
      else $error("shift amount above 32");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_err_ff |-> rsp_mult_ff == '0 && rsp_shift_ff == '0)
      else $error("error result with nonzero payload");

   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(pc_ff) == STEP_EMIT)
      else $error("result raised outside the emit step");
`endif

endmodule
